@@ src/spcd_pkg.sv @@
`default_nettype none

package spcd_pkg;

    localparam int unsigned LEN_W  = 33;  // floor square root of a 66-bit sum
    localparam int unsigned RAD_W  = 66;  // sum of three 64-bit squares
    localparam int unsigned REM_W  = 36;  // square root partial remainder
    localparam int unsigned QUO_W  = 15;  // normal magnitude, at most 16384
    localparam int unsigned DIVR_W = 48;  // divider partial remainder
    localparam int unsigned SEP_W  = 35;  // unsaturated separation
    localparam int unsigned PROD_W = 51;  // normal times scaled radius
    localparam int unsigned RND_W  = 37;  // rounded offset along the normal
    localparam int unsigned SUM_W  = 38;  // centre plus offset before saturation

    typedef struct packed {
        logic        [15:0] first_id;
        logic        [15:0] second_id;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic        [30:0] first_radius;
        logic        [30:0] second_radius;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] out_first_id;
        logic        [15:0] out_second_id;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] separation;
    } t_out_item;

    // Payload that rides along the square root cells.
    typedef struct packed {
        logic [2:0]       sgn;
        logic [2:0][31:0] mag;
        logic [2:0][31:0] s2;
        logic [30:0]      r1;
        logic [30:0]      r2;
        logic [15:0]      id1;
        logic [15:0]      id2;
        logic             zero;
    } t_sq_carry;

    // Payload that rides along the divider cells.
    typedef struct packed {
        logic [2:0]              sgn;
        logic [2:0][31:0]        s2;
        logic signed [SEP_W-1:0] k2;
        logic signed [SEP_W-1:0] sep;
        logic [15:0]             id1;
        logic [15:0]             id2;
    } t_dv_carry;

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(64'sh7FFF_FFFF);
        lo_lim = -SUM_W'(64'sh8000_0000);
        if (v > hi_lim) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ src/spcd_sqrt_cell.sv @@
`default_nettype none

// One digit of a restoring square root: takes one bit pair of the radicand.
module spcd_sqrt_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [spcd_pkg::RAD_W-1:0]        i_rad,
    input  wire logic [spcd_pkg::REM_W-1:0]        i_rem,
    input  wire logic [spcd_pkg::LEN_W-1:0]        i_root,
    input  wire spcd_pkg::t_sq_carry               i_carry,
    output logic                                   o_valid,
    output logic [spcd_pkg::RAD_W-1:0]             o_rad,
    output logic [spcd_pkg::REM_W-1:0]             o_rem,
    output logic [spcd_pkg::LEN_W-1:0]             o_root,
    output spcd_pkg::t_sq_carry                    o_carry
);

    logic                          r_valid;
    logic [spcd_pkg::RAD_W-1:0]    r_rad;
    logic [spcd_pkg::REM_W-1:0]    r_rem;
    logic [spcd_pkg::LEN_W-1:0]    r_root;
    spcd_pkg::t_sq_carry           r_carry;

    logic [spcd_pkg::REM_W-1:0]    n_rem;
    logic [spcd_pkg::LEN_W-1:0]    n_root;
    logic [spcd_pkg::REM_W-1:0]    rem_sh;
    logic [spcd_pkg::REM_W-1:0]    trial;

    always_comb begin
        rem_sh = {i_rem[spcd_pkg::REM_W-3:0], i_rad[2*IDX+1 -: 2]};
        trial  = {1'b0, i_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = rem_sh - trial;
            n_root = {i_root[spcd_pkg::LEN_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh;
            n_root = {i_root[spcd_pkg::LEN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad   <= i_rad;
            r_rem   <= n_rem;
            r_root  <= n_root;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_carry = r_carry;

endmodule

`default_nettype wire

@@ src/spcd_div_cell.sv @@
`default_nettype none

// One quotient bit of a restoring divider, for all three normal components.
module spcd_div_cell #(
    parameter int unsigned K = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [spcd_pkg::LEN_W-1:0]          i_den,
    input  wire logic [2:0][spcd_pkg::DIVR_W-1:0]    i_rem,
    input  wire logic [2:0][spcd_pkg::QUO_W-1:0]     i_quo,
    input  wire spcd_pkg::t_dv_carry                 i_carry,
    output logic                                     o_valid,
    output logic [spcd_pkg::LEN_W-1:0]               o_den,
    output logic [2:0][spcd_pkg::DIVR_W-1:0]         o_rem,
    output logic [2:0][spcd_pkg::QUO_W-1:0]          o_quo,
    output spcd_pkg::t_dv_carry                      o_carry
);

    logic                                 r_valid;
    logic [spcd_pkg::LEN_W-1:0]           r_den;
    logic [2:0][spcd_pkg::DIVR_W-1:0]     r_rem;
    logic [2:0][spcd_pkg::QUO_W-1:0]      r_quo;
    spcd_pkg::t_dv_carry                  r_carry;

    logic [2:0][spcd_pkg::DIVR_W-1:0]     n_rem;
    logic [2:0][spcd_pkg::QUO_W-1:0]      n_quo;
    logic [spcd_pkg::DIVR_W-1:0]          den_sh;

    always_comb begin
        den_sh = spcd_pkg::DIVR_W'(i_den) << K;
        for (int a = 0; a < 3; a++) begin
            n_rem[a] = i_rem[a];
            n_quo[a] = i_quo[a];
            if (i_rem[a] >= den_sh) begin
                n_rem[a]    = i_rem[a] - den_sh;
                n_quo[a][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_carry = r_carry;

endmodule

`default_nettype wire

@@ src/sphere_pair_contact_detect.sv @@
`default_nettype none

// Sphere pair contact detector.
// The input channel (i_valid, i_in, o_stall) takes one candidate sphere pair per
// transaction; a transaction completes at a rising edge where i_valid is high and
// o_stall is low. The output channel (o_valid, o_out, i_stall) delivers one
// contact record per transaction for every pair whose separation is below the
// threshold; pairs with coincident centres or a larger separation yield nothing.
// The threshold is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. Throughput is one
// pair per clock cycle while o_stall is low. A contact reaches o_valid through
// these registers: four stages take the pair in and form the differences, the
// squares and their sum, the square root is a row of 33 cells (one bit pair
// each), one stage forms the separation and the threshold test, the normal is a
// row of 15 divider cells (one quotient bit each), four more stages form the
// normal sign, the product, the rounding and the saturated contact point, and
// the output register holds the record. When i_stall holds a waiting record,
// the next record parks in a skid register and the pipeline freezes only once
// that register is full, and o_stall is high while it is full. Reset clears all
// valid flags and sets the threshold to zero; no result is lost across a stall.
module sphere_pair_contact_detect (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire spcd_pkg::t_in_item    i_in,
    output logic                       o_stall,
    output logic                       o_valid,
    output spcd_pkg::t_out_item        o_out,
    input  wire logic                  i_stall,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [31:0]           i_cfg_wr_data
);

    localparam int unsigned SQ_N = 33;
    localparam int unsigned DV_N = 15;

    logic                  en;
    logic [31:0]           r_threshold;

    // Stage A: input register.
    logic                  r_a_valid;
    spcd_pkg::t_in_item    r_a_item;

    // Stage B: differences split into magnitude and sign.
    logic                  r_b_valid;
    spcd_pkg::t_sq_carry   r_b_carry;
    spcd_pkg::t_sq_carry   n_b_carry;

    // Stage C: squares.
    logic                  r_c_valid;
    logic [2:0][63:0]      r_c_sq;
    spcd_pkg::t_sq_carry   r_c_carry;

    // Stage D: sum of squares.
    logic                         r_d_valid;
    logic [spcd_pkg::RAD_W-1:0]   r_d_sum;
    spcd_pkg::t_sq_carry          r_d_carry;
    logic [spcd_pkg::RAD_W-1:0]   n_d_sum;
    spcd_pkg::t_sq_carry          n_d_carry;

    logic                         sq_valid [SQ_N+1];
    logic [spcd_pkg::RAD_W-1:0]   sq_rad   [SQ_N+1];
    logic [spcd_pkg::REM_W-1:0]   sq_rem   [SQ_N+1];
    logic [spcd_pkg::LEN_W-1:0]   sq_root  [SQ_N+1];
    spcd_pkg::t_sq_carry          sq_carry [SQ_N+1];

    // Stage T: separation, threshold test and divider setup.
    logic                               r_t_valid;
    logic [spcd_pkg::LEN_W-1:0]         r_t_den;
    logic [2:0][spcd_pkg::DIVR_W-1:0]   r_t_rem;
    spcd_pkg::t_dv_carry                r_t_carry;
    logic signed [spcd_pkg::SEP_W-1:0]  t_sep;
    logic                               t_keep;
    logic [2:0][spcd_pkg::DIVR_W-1:0]   n_t_rem;
    spcd_pkg::t_sq_carry                t_in;

    logic                               dv_valid [DV_N+1];
    logic [spcd_pkg::LEN_W-1:0]         dv_den   [DV_N+1];
    logic [2:0][spcd_pkg::DIVR_W-1:0]   dv_rem   [DV_N+1];
    logic [2:0][spcd_pkg::QUO_W-1:0]    dv_quo   [DV_N+1];
    spcd_pkg::t_dv_carry                dv_carry [DV_N+1];

    // Stage N: signed normal.
    logic                  r_n_valid;
    logic [2:0][15:0]      r_n_nrm;
    logic [2:0][15:0]      n_n_nrm;
    spcd_pkg::t_dv_carry   r_n_carry;

    // Stage M: normal times scaled radius.
    logic                                    r_m_valid;
    logic [2:0][spcd_pkg::PROD_W-1:0]        r_m_prod;
    logic [2:0][spcd_pkg::PROD_W-1:0]        n_m_prod;
    logic [2:0][15:0]                        r_m_nrm;
    spcd_pkg::t_dv_carry                     r_m_carry;

    // Stage R: rounding of the product by 2^15.
    logic                                    r_r_valid;
    logic [2:0][spcd_pkg::RND_W-1:0]         r_r_rnd;
    logic [2:0][spcd_pkg::RND_W-1:0]         n_r_rnd;
    logic [2:0][15:0]                        r_r_nrm;
    spcd_pkg::t_dv_carry                     r_r_carry;

    // Stage P: final record.
    logic                  r_p_valid;
    spcd_pkg::t_out_item   r_p_item;
    spcd_pkg::t_out_item   n_p_item;

    // Output register and skid register.
    logic                  r_out_valid;
    spcd_pkg::t_out_item   r_out_item;
    logic                  r_skid_valid;
    spcd_pkg::t_out_item   r_skid_item;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_out   = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 32'h0;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // Valid flags of the plain stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_n_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_t_valid <= t_keep;
            r_n_valid <= dv_valid[DV_N];
            r_m_valid <= r_n_valid;
            r_r_valid <= r_m_valid;
            r_p_valid <= r_r_valid;
        end
    end

    always_comb begin
        logic signed [32:0] d [3];
        d[0] = $signed({r_a_item.first_x[31], r_a_item.first_x})
             - $signed({r_a_item.second_x[31], r_a_item.second_x});
        d[1] = $signed({r_a_item.first_y[31], r_a_item.first_y})
             - $signed({r_a_item.second_y[31], r_a_item.second_y});
        d[2] = $signed({r_a_item.first_z[31], r_a_item.first_z})
             - $signed({r_a_item.second_z[31], r_a_item.second_z});
        for (int a = 0; a < 3; a++) begin
            n_b_carry.sgn[a] = d[a][32];
            n_b_carry.mag[a] = d[a][32] ? 32'(-d[a]) : d[a][31:0];
        end
        n_b_carry.s2[0] = r_a_item.second_x;
        n_b_carry.s2[1] = r_a_item.second_y;
        n_b_carry.s2[2] = r_a_item.second_z;
        n_b_carry.r1    = r_a_item.first_radius;
        n_b_carry.r2    = r_a_item.second_radius;
        n_b_carry.id1   = r_a_item.first_id;
        n_b_carry.id2   = r_a_item.second_id;
        n_b_carry.zero  = 1'b0;
    end

    assign n_d_sum = spcd_pkg::RAD_W'(r_c_sq[0]) + spcd_pkg::RAD_W'(r_c_sq[1])
                   + spcd_pkg::RAD_W'(r_c_sq[2]);

    always_comb begin
        n_d_carry      = r_c_carry;
        n_d_carry.zero = (n_d_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item  <= i_in;
            r_b_carry <= n_b_carry;
            for (int a = 0; a < 3; a++) begin
                r_c_sq[a] <= r_b_carry.mag[a] * r_b_carry.mag[a];
            end
            r_c_carry <= r_b_carry;
            r_d_sum   <= n_d_sum;
            r_d_carry <= n_d_carry;
        end
    end

    assign sq_valid[0] = r_d_valid;
    assign sq_rad[0]   = r_d_sum;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_carry[0] = r_d_carry;

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        spcd_sqrt_cell #(
            .IDX(SQ_N - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_carry (sq_carry[g]),
            .o_valid (sq_valid[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_carry (sq_carry[g+1])
        );
    end

    assign t_in = sq_carry[SQ_N];

    always_comb begin
        t_sep = $signed({2'b00, sq_root[SQ_N]})
              - $signed({4'b0000, t_in.r1})
              - $signed({4'b0000, t_in.r2});
        t_keep = sq_valid[SQ_N] && !t_in.zero
              && (t_sep < $signed({{3{r_threshold[31]}}, r_threshold}));
        for (int a = 0; a < 3; a++) begin
            // Numerator carries half the divisor so that the quotient rounds.
            n_t_rem[a] = {2'b00, t_in.mag[a], 14'b0}
                       + {16'b0, sq_root[SQ_N][spcd_pkg::LEN_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_den       <= sq_root[SQ_N];
            r_t_rem       <= n_t_rem;
            r_t_carry.sgn <= t_in.sgn;
            r_t_carry.s2  <= t_in.s2;
            r_t_carry.sep <= t_sep;
            r_t_carry.k2  <= t_sep + $signed({3'b000, t_in.r2, 1'b0});
            r_t_carry.id1 <= t_in.id1;
            r_t_carry.id2 <= t_in.id2;
        end
    end

    assign dv_valid[0] = r_t_valid;
    assign dv_den[0]   = r_t_den;
    assign dv_rem[0]   = r_t_rem;
    assign dv_quo[0]   = '0;
    assign dv_carry[0] = r_t_carry;

    for (genvar g = 0; g < DV_N; g++) begin : g_div
        spcd_div_cell #(
            .K(DV_N - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_den   (dv_den[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .i_carry (dv_carry[g]),
            .o_valid (dv_valid[g+1]),
            .o_den   (dv_den[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_carry (dv_carry[g+1])
        );
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (dv_carry[DV_N].sgn[a]) begin
                n_n_nrm[a] = 16'h0 - {1'b0, dv_quo[DV_N][a]};
            end else begin
                n_n_nrm[a] = {1'b0, dv_quo[DV_N][a]};
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_m_prod[a] = $signed(r_n_nrm[a]) * r_n_carry.k2;
        end
    end

    always_comb begin
        logic [spcd_pkg::PROD_W-1:0] pm;
        logic [spcd_pkg::PROD_W-1:0] q;
        for (int a = 0; a < 3; a++) begin
            pm = r_m_prod[a][spcd_pkg::PROD_W-1] ? (-r_m_prod[a]) : r_m_prod[a];
            q  = (pm + spcd_pkg::PROD_W'(16384)) >> 15;
            if (r_m_prod[a][spcd_pkg::PROD_W-1]) begin
                n_r_rnd[a] = spcd_pkg::RND_W'(-q);
            end else begin
                n_r_rnd[a] = q[spcd_pkg::RND_W-1:0];
            end
        end
    end

    always_comb begin
        logic signed [spcd_pkg::SUM_W-1:0] s [3];
        for (int a = 0; a < 3; a++) begin
            s[a] = $signed({{6{r_r_carry.s2[a][31]}}, r_r_carry.s2[a]})
                 + $signed({r_r_rnd[a][spcd_pkg::RND_W-1], r_r_rnd[a]});
        end
        n_p_item.out_first_id  = r_r_carry.id1;
        n_p_item.out_second_id = r_r_carry.id2;
        n_p_item.point_x       = spcd_pkg::sat32(s[0]);
        n_p_item.point_y       = spcd_pkg::sat32(s[1]);
        n_p_item.point_z       = spcd_pkg::sat32(s[2]);
        n_p_item.normal_x      = r_r_nrm[0];
        n_p_item.normal_y      = r_r_nrm[1];
        n_p_item.normal_z      = r_r_nrm[2];
        n_p_item.separation    = spcd_pkg::sat32(
            $signed({{3{r_r_carry.sep[spcd_pkg::SEP_W-1]}}, r_r_carry.sep}));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_nrm   <= n_n_nrm;
            r_n_carry <= dv_carry[DV_N];
            r_m_prod  <= n_m_prod;
            r_m_nrm   <= r_n_nrm;
            r_m_carry <= r_n_carry;
            r_r_rnd   <= n_r_rnd;
            r_r_nrm   <= r_m_nrm;
            r_r_carry <= r_m_carry;
            r_p_item  <= n_p_item;
        end
    end

    // Output register with a skid register behind it. The pipeline only
    // advances while the skid register is empty, so a record leaving the
    // last stage always has a place to go.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_p_valid;
            end
        end else if (en && r_p_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_item <= r_skid_valid ? r_skid_item : r_p_item;
        end else if (en && r_p_valid) begin
            r_skid_item <= r_p_item;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a record while the output is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid register did not drain after the output was taken");

    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_valid |-> (r_t_den != '0))
        else $error("divider received a zero length");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((o_out.normal_x <= 16'sd16384) && (o_out.normal_x >= -16'sd16384)
                      && (o_out.normal_y <= 16'sd16384) && (o_out.normal_y >= -16'sd16384)
                      && (o_out.normal_z <= 16'sd16384) && (o_out.normal_z >= -16'sd16384)))
        else $error("normal component exceeds one");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

class contact_scoreboard;
    spcd_pkg::t_out_item expected_contacts[$];
    logic signed [31:0] threshold;
    int unsigned errors;

    function new();
        threshold = 32'sd0;
        errors = 0;
    endfunction

    static function logic [32:0] root66(logic [65:0] v);
        logic [32:0] root;
        logic [35:0] rem;
        logic [35:0] trial;
        root = '0;
        rem = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 36'(v[2*i +: 2]);
            trial = 36'({root, 2'b01});
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[31:0], 1'b1};
            end else begin
                root = {root[31:0], 1'b0};
            end
        end
        return root;
    endfunction

    static function longint round_div(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    static function logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Works out the contact record for an accepted pair, if it makes one.
    function void note_pair(spcd_pkg::t_in_item p);
        longint fc[3], sc[3], d[3], nrm;
        logic [65:0] sumsq;
        logic [63:0] m;
        longint len, sep, k2;
        spcd_pkg::t_out_item r;
        fc = '{longint'(p.first_x), longint'(p.first_y), longint'(p.first_z)};
        sc = '{longint'(p.second_x), longint'(p.second_y), longint'(p.second_z)};
        sumsq = '0;
        for (int a = 0; a < 3; a++) begin
            d[a] = fc[a] - sc[a];
            m = 64'(d[a] < 0 ? -d[a] : d[a]);
            sumsq = sumsq + 66'(m) * 66'(m);
        end
        if (sumsq == '0) return;
        len = longint'(root66(sumsq));
        sep = len - longint'(p.first_radius) - longint'(p.second_radius);
        if (!(sep < longint'(threshold))) return;
        k2 = 2 * longint'(p.second_radius) + sep;
        r.out_first_id = p.first_id;
        r.out_second_id = p.second_id;
        r.separation = clip32(sep);
        for (int a = 0; a < 3; a++) begin
            nrm = round_div(d[a] * 16384, len);
            case (a)
                0: begin
                    r.normal_x = nrm[15:0];
                    r.point_x = clip32(sc[a] + round_div(nrm * k2, 32768));
                end
                1: begin
                    r.normal_y = nrm[15:0];
                    r.point_y = clip32(sc[a] + round_div(nrm * k2, 32768));
                end
                default: begin
                    r.normal_z = nrm[15:0];
                    r.point_z = clip32(sc[a] + round_div(nrm * k2, 32768));
                end
            endcase
        end
        expected_contacts = {expected_contacts, r};
    endfunction

    function void report(string what, logic [31:0] e, logic [31:0] a);
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, what, e, a);
        errors++;
    endfunction

    function void check_contact(spcd_pkg::t_out_item got);
        spcd_pkg::t_out_item e;
        if (expected_contacts.size() == 0) begin
            $display("%0t: unexpected contact, expected none, actual %h", $realtime, got);
            errors++;
            return;
        end
        e = expected_contacts.pop_front();
        if (got.out_first_id !== e.out_first_id) report("first id", e.out_first_id, got.out_first_id);
        if (got.out_second_id !== e.out_second_id)
            report("second id", e.out_second_id, got.out_second_id);
        if (got.point_x !== e.point_x) report("point x", e.point_x, got.point_x);
        if (got.point_y !== e.point_y) report("point y", e.point_y, got.point_y);
        if (got.point_z !== e.point_z) report("point z", e.point_z, got.point_z);
        if (got.normal_x !== e.normal_x) report("normal x", e.normal_x, got.normal_x);
        if (got.normal_y !== e.normal_y) report("normal y", e.normal_y, got.normal_y);
        if (got.normal_z !== e.normal_z) report("normal z", e.normal_z, got.normal_z);
        if (got.separation !== e.separation) report("separation", e.separation, got.separation);
    endfunction
endclass

module tb;
    localparam int LATENCY = 58;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    spcd_pkg::t_in_item i_in = '0;
    logic o_stall;
    logic o_valid;
    spcd_pkg::t_out_item o_out;
    logic i_stall = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;

    contact_scoreboard board = new();
    int unsigned cycles = 0;
    bit allow_idle = 1'b1;

    sphere_pair_contact_detect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in(i_in),
        .o_stall(o_stall), .o_valid(o_valid), .o_out(o_out), .i_stall(i_stall),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL sphere_pair_contact_detect");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) board.check_contact(o_out);
    end

    // Receiver stalls in random bursts.
    initial begin
        @(negedge i_clk);
        forever begin
            if (allow_idle && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(negedge i_clk);
        end
    end

    function automatic logic signed [31:0] rnd_coord(bit near);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return near ? 32'($signed($urandom_range(0, 2000000)) - 1000000)
                                 : $urandom;
        endcase
    endfunction

    function automatic spcd_pkg::t_in_item rnd_pair();
        spcd_pkg::t_in_item p;
        bit near;
        near = $urandom_range(0, 3) != 0;
        p.first_id = 16'($urandom);
        p.second_id = 16'($urandom);
        p.first_x = rnd_coord(near);
        p.first_y = rnd_coord(near);
        p.first_z = rnd_coord(near);
        p.second_x = rnd_coord(near);
        p.second_y = rnd_coord(near);
        p.second_z = rnd_coord(near);
        if ($urandom_range(0, 7) == 0) begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
            p.second_z = p.first_z;
        end
        p.first_radius = near ? 31'($urandom_range(0, 1500000)) : 31'($urandom);
        p.second_radius = near ? 31'($urandom_range(0, 1500000)) : 31'($urandom);
        return p;
    endfunction

    task automatic send_pair(spcd_pkg::t_in_item p);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in <= p;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_pair(p);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.expected_contacts.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic set_threshold(logic [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.threshold = v;
    endtask

    task automatic directed_pair(logic signed [31:0] fx, fy, fz, sx, sy, sz,
                                 logic [30:0] r1, r2);
        spcd_pkg::t_in_item p;
        p.first_id = 16'($urandom);
        p.second_id = 16'($urandom);
        p = '{16'hFFFF, 16'h0000, fx, fy, fz, sx, sy, sz, r1, r2};
        send_pair(p);
    endtask

    initial begin
        logic [31:0] settings[5];
        settings = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0010_0000};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset threshold of zero, then a generous one, then the most negative one.
        directed_pair(32'sh0001_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000);
        directed_pair(100, 200, 300, 100, 200, 300, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        wait_drained();
        set_threshold(32'h7FFF_FFFF);
        directed_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
        directed_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      31'h7FFF_FFFF, 31'h7FFF_FFFF);
        directed_pair(1, 0, 0, 0, 0, 0, 0, 0);
        directed_pair(0, -1, 0, 0, 0, 0, 31'h7FFF_FFFF, 0);
        directed_pair(0, 0, 1, 0, 0, 0, 0, 31'h7FFF_FFFF);
        directed_pair(3, 4, 0, 0, 0, 0, 5, 0);
        directed_pair(1, 1, 1, 0, 0, 0, 2, 3);
        directed_pair(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 31'h7FFF_FFFF, 0);
        directed_pair(5, 5, 5, 5, 5, 5, 0, 0);
        directed_pair(-7, 3, -2, 9, -4, 6, 10, 1);
        wait_drained();
        set_threshold(32'h8000_0000);
        directed_pair(1, 2, 3, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        directed_pair(1, 2, 3, 0, 0, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            set_threshold(settings[ph]);
            if (ph == 4) allow_idle = 1'b0;
            for (int n = 0; n < 100; n++) send_pair(rnd_pair());
            wait_drained();
        end

        if (board.errors == 0 && board.expected_contacts.size() == 0) begin
            $display("PASS sphere_pair_contact_detect");
        end else begin
            $display("FAIL sphere_pair_contact_detect");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/spcd_pkg.sv
src/spcd_sqrt_cell.sv
src/spcd_div_cell.sv
src/sphere_pair_contact_detect.sv
test/tb.sv
